### src/ggsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ggsd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_A,
        ST_SUM_T,
        ST_MUL_C,
        ST_WRITE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_CORNER
    } t_state;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] REG_GRID_SIZE   = 3'd0;
    localparam logic [2:0] REG_SWEEP_COUNT = 3'd1;
    localparam logic [2:0] REG_COEF_A      = 3'd2;
    localparam logic [2:0] REG_COEF_C      = 3'd3;
    localparam logic [2:0] REG_BOUNDARY    = 3'd4;

    localparam logic [1:0] BND_NEG_LR = 2'd1;
    localparam logic [1:0] BND_NEG_TB = 2'd2;

endpackage
`default_nettype wire

### src/grid_gauss_seidel_diffuse.sv
`timescale 1ns / 1ps
`default_nettype none
// Gauss-Seidel grid solver. Load and read requests are taken one per cycle while
// o_busy is low; a read result appears on the cycle after the request, marked by
// o_result_valid for one cycle, and the receiver cannot stall it. A solve request
// holds o_busy high, then pulses a done result. The solve works through the single
// read port of the cell memory: each interior cell reads its neighbours, then runs
// the states MUL_A, SUM_T, MUL_C and WRITE; each edge cell is read and then written,
// and each corner is the average of two reads. A solve with zero sweeps reports
// done on the next cycle. Every cell must be loaded first.
module grid_gauss_seidel_diffuse import ggsd_pkg::*; #(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [5:0]  i_column,
    input  wire logic [5:0]  i_row,
    input  wire logic [31:0] i_start_value,
    input  wire logic [31:0] i_source_value,
    output logic             o_result_valid,
    output logic             o_result_kind,
    output logic [31:0]      o_value,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_SIZE);
    localparam int DEPTH = 1 << (2 * AW);
    localparam int VW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam logic [64:0] VMAX_U = (65'd1 << (VW - 1)) - 65'd1;
    localparam logic [31:0] VMAX32 = 32'(VMAX_U);
    localparam logic [31:0] VMIN32 = ~VMAX32;

    function automatic logic [31:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [64:0] nm;
        nm = -mag;
        if (!neg) begin
            sat_mag = (mag > VMAX_U) ? VMAX32 : mag[31:0];
        end else begin
            sat_mag = (mag > VMAX_U + 65'd1) ? VMIN32 : nm[31:0];
        end
    endfunction

    function automatic logic [64:0] abs32(input logic [31:0] v);
        logic [64:0] e;
        e = {{33{v[31]}}, v};
        abs32 = v[31] ? -e : e;
    endfunction

    // configuration
    logic [6:0]  r_grid;
    logic [7:0]  r_sweeps;
    logic [31:0] r_coef_a;
    logic [31:0] r_coef_c;
    logic [1:0]  r_bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= 7'd64;
            r_sweeps <= 8'd20;
            r_coef_a <= 32'd65536;
            r_coef_c <= 32'd16384;
            r_bnd    <= 2'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRID_SIZE:   r_grid   <= i_cfg_data[6:0];
                REG_SWEEP_COUNT: r_sweeps <= i_cfg_data[7:0];
                REG_COEF_A:      r_coef_a <= i_cfg_data;
                REG_COEF_C:      r_coef_c <= i_cfg_data;
                REG_BOUNDARY:    r_bnd    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [9:0]    gsz;
    logic [AW-1:0] last;
    always_comb begin
        gsz = {3'd0, r_grid};
        if (gsz < 10'd3) begin
            last = AW'(2);
        end else if (gsz > 10'(MAX_SIZE)) begin
            last = AW'(MAX_SIZE - 1);
        end else begin
            last = AW'(gsz - 10'd1);
        end
    end

    // control
    t_state        r_state, n_state;
    logic [AW-1:0] r_x, n_x, r_y, n_y, r_k, n_k;
    logic [2:0]    r_ph, n_ph;
    logic [1:0]    r_side, n_side;
    logic [7:0]    r_sweep, n_sweep;
    logic          r_done, n_done;
    logic          r_rd_pend, r_rd_in;

    logic          accept, in_grid;
    logic [AW-1:0] in_x, in_y;
    assign accept  = i_start && (r_state == ST_IDLE);
    assign in_grid = (32'(i_column) < 32'(MAX_SIZE)) && (32'(i_row) < 32'(MAX_SIZE));
    assign in_x    = AW'(i_column);
    assign in_y    = AW'(i_row);

    // memories
    logic [31:0]     cell_mem [DEPTH];
    logic [31:0]     src_mem  [DEPTH];
    logic [31:0]     r_rdata, r_src;
    logic [2*AW-1:0] rd_addr, wr_addr;
    logic            wr_en;
    logic [31:0]     wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (accept && i_kind == KIND_LOAD && in_grid) begin
            src_mem[{in_x, in_y}] <= sat_mag(i_source_value[31], abs32(i_source_value));
        end
        r_rdata <= cell_mem[rd_addr];
        r_src   <= src_mem[{r_x, r_y}];
    end

    // datapath
    logic signed [34:0] r_sum;
    logic               r_neg1, r_neg2;
    logic [50:0]        r_pah, r_pal;
    logic signed [48:0] r_t;
    logic [63:0]        r_pch, r_pcl;
    logic [31:0]        r_hold;

    logic [34:0]        mag1;
    logic [51:0]        rnd1;
    logic signed [53:0] q1, t_full;
    logic [47:0]        mag2;
    logic [64:0]        rnd2;
    logic [31:0]        cell_new;
    logic signed [32:0] avg_sum;

    always_comb begin
        mag1   = r_sum[34] ? 35'(-r_sum) : 35'(r_sum);
        rnd1   = 52'(r_pah) + 52'((r_pal + 51'h8000) >> 16);
        q1     = r_neg1 ? -$signed({2'b00, rnd1}) : $signed({2'b00, rnd1});
        t_full = q1 + {{22{r_src[31]}}, r_src};
        mag2   = r_t[48] ? 48'(-r_t) : 48'(r_t);
        rnd2   = 65'(r_pch) + 65'((r_pcl + 64'h8000) >> 16);
        cell_new = sat_mag(r_neg2 && rnd2 != 65'd0, rnd2);
        avg_sum = $signed({r_hold[31], r_hold}) + $signed({r_rdata[31], r_rdata});
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            if (r_ph == 3'd1) begin
                r_sum <= 35'($signed(r_rdata));
            end else if (r_ph != 3'd0) begin
                r_sum <= r_sum + 35'($signed(r_rdata));
            end
        end
        if (r_state == ST_MUL_A) begin
            r_neg1 <= r_sum[34];
            r_pah  <= 51'(mag1) * 51'(r_coef_a[31:16]);
            r_pal  <= 51'(mag1) * 51'(r_coef_a[15:0]);
        end
        if (r_state == ST_SUM_T) begin
            if (t_full > 54'sh800000000000) begin
                r_t <= 49'sh0800000000000;
            end else if (t_full < -54'sh800000000000) begin
                r_t <= -49'sh0800000000000;
            end else begin
                r_t <= 49'(t_full);
            end
        end
        if (r_state == ST_MUL_C) begin
            r_neg2 <= r_t[48];
            r_pch  <= 64'(mag2) * 64'(r_coef_c[31:16]);
            r_pcl  <= 64'(mag2) * 64'(r_coef_c[15:0]);
        end
        if (r_state == ST_CORNER && r_ph == 3'd1) begin
            r_hold <= r_rdata;
        end
    end

    // edge and corner addressing
    logic [AW-1:0] e_sx, e_sy, e_dx, e_dy, c_px, c_py, c_qx, c_qy, c_dx, c_dy;
    logic          e_neg;
    logic [AW-1:0] lm1;
    assign lm1 = AW'(last - 1'b1);

    always_comb begin
        e_sx = r_k; e_sy = AW'(1); e_dx = r_k; e_dy = '0;
        e_neg = (r_bnd == BND_NEG_TB);
        case (r_side)
            2'd0: begin e_sx = r_k; e_sy = AW'(1); e_dx = r_k; e_dy = '0; end
            2'd1: begin e_sx = r_k; e_sy = lm1; e_dx = r_k; e_dy = last; end
            2'd2: begin
                e_sx = AW'(1); e_sy = r_k; e_dx = '0; e_dy = r_k;
                e_neg = (r_bnd == BND_NEG_LR);
            end
            default: begin
                e_sx = lm1; e_sy = r_k; e_dx = last; e_dy = r_k;
                e_neg = (r_bnd == BND_NEG_LR);
            end
        endcase
        case (r_side)
            2'd0: begin
                c_px = AW'(1); c_py = '0; c_qx = '0; c_qy = AW'(1); c_dx = '0; c_dy = '0;
            end
            2'd1: begin
                c_px = AW'(1); c_py = last; c_qx = '0; c_qy = lm1; c_dx = '0; c_dy = last;
            end
            2'd2: begin
                c_px = lm1; c_py = '0; c_qx = last; c_qy = AW'(1); c_dx = last; c_dy = '0;
            end
            default: begin
                c_px = lm1; c_py = last; c_qx = last; c_qy = lm1; c_dx = last; c_dy = last;
            end
        endcase
    end

    // next state, memory ports
    always_comb begin
        n_state = r_state;
        n_x = r_x; n_y = r_y; n_k = r_k; n_ph = r_ph; n_side = r_side;
        n_sweep = r_sweep;
        n_done  = 1'b0;
        rd_addr = {in_x, in_y};
        wr_en   = 1'b0;
        wr_addr = {in_x, in_y};
        wr_data = sat_mag(i_start_value[31], abs32(i_start_value));
        case (r_state)
            ST_IDLE: begin
                if (accept && i_kind == KIND_LOAD && in_grid) begin
                    wr_en = 1'b1;
                end
                if (accept && i_kind == KIND_SOLVE) begin
                    if (r_sweeps == 8'd0) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = ST_READ;
                        n_x = AW'(1); n_y = AW'(1); n_ph = 3'd0; n_sweep = 8'd0;
                    end
                end
            end
            ST_READ: begin
                case (r_ph)
                    3'd0:    rd_addr = {AW'(r_x + 1'b1), r_y};
                    3'd1:    rd_addr = {AW'(r_x - 1'b1), r_y};
                    3'd2:    rd_addr = {r_x, AW'(r_y + 1'b1)};
                    default: rd_addr = {r_x, AW'(r_y - 1'b1)};
                endcase
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd4) begin
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: n_state = ST_SUM_T;
            ST_SUM_T: n_state = ST_MUL_C;
            ST_MUL_C: n_state = ST_WRITE;
            ST_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = {r_x, r_y};
                wr_data = cell_new;
                n_ph    = 3'd0;
                n_state = ST_READ;
                if (r_x == lm1) begin
                    n_x = AW'(1);
                    if (r_y == lm1) begin
                        n_state = ST_EDGE_RD;
                        n_k = AW'(1); n_side = 2'd0;
                    end else begin
                        n_y = AW'(r_y + 1'b1);
                    end
                end else begin
                    n_x = AW'(r_x + 1'b1);
                end
            end
            ST_EDGE_RD: begin
                rd_addr = {e_sx, e_sy};
                n_state = ST_EDGE_WR;
            end
            ST_EDGE_WR: begin
                wr_en   = 1'b1;
                wr_addr = {e_dx, e_dy};
                wr_data = e_neg ? sat_mag(!r_rdata[31] && r_rdata != 32'd0, abs32(r_rdata))
                                : r_rdata;
                n_side  = r_side + 2'd1;
                n_state = ST_EDGE_RD;
                if (r_side == 2'd3) begin
                    if (r_k == lm1) begin
                        n_state = ST_CORNER; n_ph = 3'd0;
                    end else begin
                        n_k = AW'(r_k + 1'b1);
                    end
                end
            end
            ST_CORNER: begin
                rd_addr = (r_ph == 3'd0) ? {c_px, c_py} : {c_qx, c_qy};
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd2) begin
                    wr_en   = 1'b1;
                    wr_addr = {c_dx, c_dy};
                    wr_data = 32'(avg_sum >>> 1);
                    n_ph    = 3'd0;
                    n_side  = r_side + 2'd1;
                    if (r_side == 2'd3) begin
                        n_sweep = r_sweep + 8'd1;
                        if (r_sweep + 8'd1 == r_sweeps) begin
                            n_state = ST_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_state = ST_READ;
                            n_x = AW'(1); n_y = AW'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_done    <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_in   <= 1'b0;
            r_x <= '0; r_y <= '0; r_k <= '0; r_ph <= '0; r_side <= '0; r_sweep <= '0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_rd_pend <= accept && i_kind == KIND_READ;
            r_rd_in   <= in_grid;
            r_x <= n_x; r_y <= n_y; r_k <= n_k; r_ph <= n_ph; r_side <= n_side;
            r_sweep <= n_sweep;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_rd_pend || r_done;
    assign o_result_kind  = r_done;
    assign o_value        = (r_rd_pend && r_rd_in) ? r_rdata : 32'd0;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE && !r_rd_pend))
        else $error("done result while solver active");
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind) |-> (o_value == 32'd0))
        else $error("done result with nonzero value");
    a_solve_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_SOLVE) |=> (o_busy || (o_result_valid && o_result_kind)))
        else $error("solve request dropped");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_result_valid && o_result_kind))
        else $error("solve ended without done");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ggsd_pkg::*;

    localparam int GRID_MAX = 64;
    localparam int LARGE_N = 16;
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint SUM_CLAMP = 64'sd1 << 47;

    typedef struct {
        logic        kind;
        logic [31:0] value;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_kind;
    logic [5:0]  i_column;
    logic [5:0]  i_row;
    logic [31:0] i_start_value;
    logic [31:0] i_source_value;
    logic        o_result_valid;
    logic        o_result_kind;
    logic [31:0] o_value;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    grid_gauss_seidel_diffuse uut (.*);

    // predictor state
    int          cell_grid [GRID_MAX][GRID_MAX];
    int          src_grid  [GRID_MAX][GRID_MAX];
    bit          loaded    [GRID_MAX][GRID_MAX];
    logic [6:0]  grid_n;
    logic [7:0]  sweeps;
    logic [31:0] weight_a;
    logic [31:0] recip_c;
    logic [1:0]  bnd_mode;

    t_result pending_results[$];
    int      errors;
    int      gap_pct;
    longint  cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d value=%h", o_result_kind, o_value);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, o_result_kind);
                    errors++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, o_value);
                    errors++;
                end
            end
        end
    end

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // round half away from zero of x * k / 2^16
    function automatic longint scale_q16(longint x, logic [31:0] k);
        longint unsigned mag;
        longint unsigned r;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        r = mag * {48'd0, k[31:16]} + ((mag * {48'd0, k[15:0]} + 64'h8000) >> 16);
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic int negate_sat(int v);
        return sat32(-longint'(v));
    endfunction

    function automatic int corner_avg(int p, int q);
        longint s;
        s = longint'(p) + longint'(q);
        if (s >= 0) return int'(s / 2);
        return int'(-((-s + 1) / 2));
    endfunction

    function automatic int active_size();
        if (grid_n < 3) return 3;
        if (grid_n > GRID_MAX) return GRID_MAX;
        return int'(grid_n);
    endfunction

    task automatic fix_borders(int n);
        int last;
        int t, b, l, r;
        last = n - 1;
        for (int k = 1; k < last; k++) begin
            t = cell_grid[k][1];
            b = cell_grid[k][last - 1];
            l = cell_grid[1][k];
            r = cell_grid[last - 1][k];
            cell_grid[k][0]    = (bnd_mode == BND_NEG_TB) ? negate_sat(t) : t;
            cell_grid[k][last] = (bnd_mode == BND_NEG_TB) ? negate_sat(b) : b;
            cell_grid[0][k]    = (bnd_mode == BND_NEG_LR) ? negate_sat(l) : l;
            cell_grid[last][k] = (bnd_mode == BND_NEG_LR) ? negate_sat(r) : r;
        end
        cell_grid[0][0]       = corner_avg(cell_grid[1][0], cell_grid[0][1]);
        cell_grid[0][last]    = corner_avg(cell_grid[1][last], cell_grid[0][last - 1]);
        cell_grid[last][0]    = corner_avg(cell_grid[last - 1][0], cell_grid[last][1]);
        cell_grid[last][last] = corner_avg(cell_grid[last - 1][last],
                                           cell_grid[last][last - 1]);
    endtask

    task automatic relax_grid();
        int n;
        longint nsum, t;
        n = active_size();
        for (int s = 0; s < sweeps; s++) begin
            for (int y = 1; y < n - 1; y++)
                for (int x = 1; x < n - 1; x++) begin
                    nsum = longint'(cell_grid[x + 1][y]) + cell_grid[x - 1][y]
                         + cell_grid[x][y + 1] + cell_grid[x][y - 1];
                    t = longint'(src_grid[x][y]) + scale_q16(nsum, weight_a);
                    if (t > SUM_CLAMP) t = SUM_CLAMP;
                    if (t < -SUM_CLAMP) t = -SUM_CLAMP;
                    cell_grid[x][y] = sat32(scale_q16(t, recip_c));
                end
            fix_borders(n);
        end
    endtask

    task automatic send_req(logic [1:0] kind, int col, int row,
                            logic [31:0] sv, logic [31:0] src);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start        = 1'b1;
        i_kind         = kind;
        i_column       = col[5:0];
        i_row          = row[5:0];
        i_start_value  = sv;
        i_source_value = src;
        do @(posedge i_clk); while (o_busy);
        case (kind)
            KIND_LOAD: begin
                cell_grid[col][row] = int'(sv);
                src_grid[col][row]  = int'(src);
                loaded[col][row]    = 1'b1;
            end
            KIND_SOLVE: begin
                relax_grid();
                res.kind = RES_DONE;
                res.value = '0;
                pending_results.push_back(res);
            end
            KIND_READ: begin
                res.kind = RES_READ;
                res.value = cell_grid[col][row];
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    // hold off until the block is idle and every result is in
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            REG_GRID_SIZE:   grid_n   = data[6:0];
            REG_SWEEP_COUNT: sweeps   = data[7:0];
            REG_COEF_A:      weight_a = data;
            REG_COEF_C:      recip_c  = data;
            REG_BOUNDARY:    bnd_mode = data[1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int n, int sw, logic [31:0] a, logic [31:0] c, int mode);
        drain();
        cfg_write(REG_GRID_SIZE, n);
        cfg_write(REG_SWEEP_COUNT, sw);
        cfg_write(REG_COEF_A, a);
        cfg_write(REG_COEF_C, c);
        cfg_write(REG_BOUNDARY, mode);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(32'h0003ffff);
            3: return -$urandom_range(32'h0003ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return $urandom_range(32'h00020000);
            default: return $urandom;
        endcase
    endfunction

    task automatic read_written();
        int x, y;
        do begin
            x = $urandom_range(GRID_MAX - 1);
            y = $urandom_range(GRID_MAX - 1);
        end while (!loaded[x][y]);
        send_req(KIND_READ, x, y, $urandom, $urandom);
    endtask

    task automatic test_directed();
        set_config(3, 1, 32'h0001_0000, 32'h0000_4000, 0);
        send_req(KIND_LOAD, 0, 0, 32'h7fffffff, 32'h80000000);
        send_req(KIND_LOAD, 1, 0, 32'h80000000, 32'h7fffffff);
        send_req(KIND_LOAD, 2, 0, 32'h0, 32'hffffffff);
        send_req(KIND_LOAD, 0, 1, 32'hffffffff, 32'h0);
        send_req(KIND_LOAD, 1, 1, 32'h0001_0000, 32'h7fffffff);
        send_req(KIND_LOAD, 2, 1, 32'h7fffffff, 32'h0);
        send_req(KIND_LOAD, 0, 2, 32'h80000000, 32'h0);
        send_req(KIND_LOAD, 1, 2, 32'h7fffffff, 32'h80000000);
        send_req(KIND_LOAD, 2, 2, 32'h80000000, 32'h1234_5678);
        send_req(KIND_LOAD, 63, 63, 32'h5555aaaa, 32'haaaa5555);
        send_req(KIND_READ, 63, 63, 32'h0, 32'h0);
        send_req(KIND_NONE, 5, 5, 32'h0, 32'h0);
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        for (int i = 0; i < 3; i++) send_req(KIND_READ, i, i, 32'h0, 32'h0);
        // zero sweeps only reports done
        set_config(3, 0, 32'hffffffff, 32'hffffffff, 1);
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        set_config(2, 255, 32'hffffffff, 32'hffffffff, 1);
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        send_req(KIND_READ, 0, 1, 32'h0, 32'h0);
        set_config(3, 2, 32'h0000_8000, 32'h0, 2);
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        set_config(3, 3, 32'h0001_0000, 32'h0000_4000, 3);
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        send_req(KIND_READ, 2, 2, 32'h0, 32'h0);
    endtask

    task automatic test_random_solves(int pct, int rounds);
        int n, reg_n;
        drain();
        gap_pct = pct;
        for (int r = 0; r < rounds; r++) begin
            reg_n = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
            set_config(reg_n, $urandom_range(6), rand_coef(), rand_coef(),
                       $urandom_range(3));
            n = active_size();
            for (int y = 0; y < n; y++)
                for (int x = 0; x < n; x++)
                    send_req(KIND_LOAD, x, y, rand_value(), rand_value());
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(3))
                    0: send_req(KIND_LOAD, $urandom_range(63), $urandom_range(63),
                                rand_value(), rand_value());
                    1: send_req(KIND_NONE, $urandom_range(63), $urandom_range(63),
                                $urandom, $urandom);
                    default: read_written();
                endcase
            end
            send_req(KIND_SOLVE, $urandom_range(63), $urandom_range(63), $urandom, $urandom);
            for (int i = 0; i < 4; i++) read_written();
        end
    endtask

    task automatic test_large_grid();
        set_config(LARGE_N, 1, 32'h0000_4000, 32'h0001_0000, 1);
        gap_pct = 0;
        for (int y = 0; y < LARGE_N; y++)
            for (int x = 0; x < LARGE_N; x++)
                send_req(KIND_LOAD, x, y, rand_value(), rand_value());
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) read_written();
        set_config(LARGE_N, 2, 32'h0001_0000, 32'h0000_4000, 2);
        send_req(KIND_SOLVE, 0, 0, 32'h0, 32'h0);
        send_req(KIND_READ, LARGE_N - 1, LARGE_N - 1, 32'h0, 32'h0);
        send_req(KIND_READ, 0, 0, 32'h0, 32'h0);
        for (int i = 0; i < 6; i++) read_written();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        gap_pct = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = KIND_LOAD;
        i_column = '0;
        i_row = '0;
        i_start_value = '0;
        i_source_value = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_GRID_SIZE;
        i_cfg_data = '0;
        grid_n = 7'd64;
        sweeps = 8'd20;
        weight_a = 32'h0001_0000;
        recip_c = 32'h0000_4000;
        bnd_mode = 2'd0;
        for (int x = 0; x < GRID_MAX; x++)
            for (int y = 0; y < GRID_MAX; y++) begin
                cell_grid[x][y] = 0;
                src_grid[x][y] = 0;
                loaded[x][y] = 1'b0;
            end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_solves(0, 3);
        test_random_solves(66, 3);
        test_random_solves(17, 3);
        test_random_solves(0, 3);
        test_large_grid();

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
